[hw/rtl/mpp_pkg.sv]
// Shared constants and types for the monochrome page packer.
package mpp_pkg;

  // Default image limits
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;

  // Rows in one page band
  localparam int BAND_ROWS = 8;

  // Register reset values
  localparam logic [7:0] WHITE_VALUE_RST   = 8'd1;
  localparam logic [6:0] IMAGE_ROWS_RST    = 7'd64;
  localparam logic [7:0] IMAGE_COLUMNS_RST = 8'd128;

  // Configuration register index (word address)
  typedef enum logic [1:0] {
    REG_WHITE_VALUE   = 2'd0,
    REG_IMAGE_ROWS    = 2'd1,
    REG_IMAGE_COLUMNS = 2'd2
  } reg_index_t;

endpackage

[hw/rtl/mpp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/monochrome_page_packer.sv]
// Top level of the monochrome page packer: pixel stream in, page column bytes out.
//
//  channel | dir | handshake                 | beat content
//  --------+-----+---------------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready       | s_tdata[7:0] pixel
//  m_*     | out | m_tvalid / m_tready       | m_tdata byte, page, column; m_tlast = image done
//  apb     | in  | psel, penable, pready = 1 | white_value, image_rows, image_columns
//
//  One pixel beat per cycle unless stalled; bytes leave via stage A and the output register.
//  Stage A holds the column byte read from the band RAM (one read, one write port);
//  a byte written by the beat just ahead to the same column is forwarded past the RAM.
//  rst clears the row and column counters and the pipeline valids; band RAM is not
//  cleared, as the first row of every band starts each column byte fresh.
//  s_tready drops only while stage A holds a finished byte and the output beat is stalled.
module monochrome_page_packer
  import mpp_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // pixel stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  // packed byte stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] packed_byte, [10:8] page, [17:11] column, rest zero
  output logic        m_tlast,   // image_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int RCMP_W = (RCNT_W > 7) ? RCNT_W : 7;
  localparam int CCMP_W = (CCNT_W > 8) ? CCNT_W : 8;

  // ---------------------------------------------------------------- registers
  logic [7:0] white_value;
  logic [6:0] image_rows;
  logic [7:0] image_columns;

  logic             cfg_write;
  reg_index_t       cfg_sel;

  assign pready    = 1'b1;
  assign cfg_sel   = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_value   <= WHITE_VALUE_RST;
      image_rows    <= IMAGE_ROWS_RST;
      image_columns <= IMAGE_COLUMNS_RST;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_WHITE_VALUE:   white_value   <= pwdata[7:0];
        REG_IMAGE_ROWS:    image_rows    <= pwdata[6:0];
        REG_IMAGE_COLUMNS: image_columns <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_WHITE_VALUE:   prdata = {24'd0, white_value};
      REG_IMAGE_ROWS:    prdata = {25'd0, image_rows};
      REG_IMAGE_COLUMNS: prdata = {24'd0, image_columns};
      default:           prdata = 32'd0;
    endcase
  end

  // Clamp the image size into 1..MAX
  logic [RCMP_W-1:0] rows_cfg;
  logic [CCMP_W-1:0] cols_cfg;
  logic [RCNT_W-1:0] rows_eff;
  logic [CCNT_W-1:0] cols_eff;

  assign rows_cfg = RCMP_W'(image_rows);
  assign cols_cfg = CCMP_W'(image_columns);

  always_comb begin
    if (rows_cfg == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (rows_cfg > RCMP_W'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      cols_eff = CCNT_W'(1);
    end else if (cols_cfg > CCMP_W'(MAX_COLUMNS)) begin
      cols_eff = CCNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CCNT_W'(cols_cfg);
    end
  end

  // ---------------------------------------------------------------- pipeline control
  logic             adv;
  logic             accept;
  logic             a_valid;
  logic             a_band_end;
  logic             o_valid;

  // Stage A moves on unless it holds a finished byte that the output cannot take
  assign adv      = !a_valid || !a_band_end || !o_valid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  // ---------------------------------------------------------------- position counters
  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count_next;
  logic [COL_W-1:0]  col_count_next;
  logic [ROW_W-1:0]  r_cur;
  logic [COL_W-1:0]  c_cur;
  logic [RCNT_W-1:0] r_inc;
  logic [CCNT_W-1:0] c_inc;
  logic              last_row;
  logic              last_col;
  logic [31:0]       r_wide;
  logic [31:0]       c_wide;

  always_comb begin
    // Restart a counter left beyond a smaller image
    r_cur    = (RCNT_W'(row_count) >= rows_eff) ? '0 : row_count;
    c_cur    = (CCNT_W'(col_count) >= cols_eff) ? '0 : col_count;
    r_inc    = RCNT_W'(r_cur) + RCNT_W'(1);
    c_inc    = CCNT_W'(c_cur) + CCNT_W'(1);
    last_row = (r_inc == rows_eff);
    last_col = (c_inc == cols_eff);
    r_wide   = 32'(r_cur);
    c_wide   = 32'(c_cur);

    if (last_col) begin
      col_count_next = '0;
      row_count_next = last_row ? '0 : ROW_W'(r_inc);
    end else begin
      col_count_next = COL_W'(c_inc);
      row_count_next = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // ---------------------------------------------------------------- band RAM
  logic [COL_W-1:0] a_col;
  logic [7:0]       ram_rdata;
  logic [7:0]       band_byte;
  logic             ram_we;

  assign ram_we = adv && a_valid;

  mpp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_COLUMNS)
  ) u_band_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_col),
    .wdata (band_byte),
    .re    (accept),
    .raddr (c_cur),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- stage A
  logic [2:0] a_sub;
  logic       a_lit;
  logic       a_done;
  logic [2:0] a_page;
  logic [6:0] a_column;
  logic       fwd_hit;
  logic [7:0] fwd_data;
  logic [7:0] band_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (adv) begin
      a_valid <= s_tvalid;
      // The RAM reads old data when a write to the same column lands on the same edge
      fwd_hit <= a_valid && s_tvalid && (a_col == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data   <= band_byte;
      a_col      <= c_cur;
      a_sub      <= r_wide[2:0];
      a_lit      <= (s_tdata == white_value);
      a_band_end <= (r_wide[2:0] == 3'(BAND_ROWS - 1)) || last_row;
      a_done     <= last_row && last_col;
      a_page     <= r_wide[5:3];
      a_column   <= c_wide[6:0];
    end
  end

  // First row of a band starts the column byte fresh
  always_comb begin
    if (a_sub == 3'd0) begin
      band_base = 8'd0;
    end else if (fwd_hit) begin
      band_base = fwd_data;
    end else begin
      band_base = ram_rdata;
    end
    band_byte = band_base | (a_lit ? (8'd1 << a_sub) : 8'd0);
  end

  // ---------------------------------------------------------------- output register
  logic       o_valid_next;
  logic       o_load;
  logic [7:0] o_byte;
  logic [2:0] o_page;
  logic [6:0] o_column;
  logic       o_last;

  assign o_load = adv && a_valid && a_band_end;

  always_comb begin
    if (o_load) begin
      o_valid_next = 1'b1;
    end else if (m_tready) begin
      o_valid_next = 1'b0;
    end else begin
      o_valid_next = o_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_byte   <= band_byte;
      o_page   <= a_page;
      o_column <= a_column;
      o_last   <= a_done;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {6'd0, o_column, o_page, o_byte};
  assign m_tlast  = o_last;

  // ---------------------------------------------------------------- checks
  a_stall_only_on_output : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output free");

  a_no_beat_mid_band : assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_band_end && !(m_tvalid && !m_tready)) |=> !m_tvalid)
    else $error("output beat from a pixel inside a band");

  a_forward_same_col : assert property (@(posedge clk) disable iff (rst)
    (accept && a_valid && (a_col == c_cur)) |=> (fwd_hit && fwd_data == $past(band_byte)))
    else $error("column byte not forwarded past RAM write");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_band_end && !adv) |=> (a_valid && $stable(a_col) && $stable(a_sub)))
    else $error("stage A lost a finished byte during stall");

endmodule
